@@ rtl/core/integer_to_ascii_formatter_unit_defines.svh @@
// Assertion macros used by the formatter top level.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`endif

@@ rtl/core/itoa_pkg.sv @@
// Types, constants and helpers for the integer-to-ASCII formatter.
`default_nettype none
package itoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int NUM_CELLS  = 20;
  localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
  localparam int HEX_BASE   = NUM_CELLS - HEX_DIGITS;
  localparam int REMAIN_W   = $clog2(NUM_CELLS + 1);
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
  localparam logic [DIGIT_W-1:0] DEC_MAX   = 4'd9;

  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_HEX = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d > DEC_MAX) begin
      g = CHAR_LOW_A + {3'b000, d} - 7'd10;
    end else begin
      g = CHAR_ZERO + {3'b000, d};
    end
    return g;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_to_ascii_formatter_unit.sv @@
// Top level of the integer-to-ASCII formatter: control FSM and digit-cell row.
// Usage:
//   req channel (req_valid / req_stall / req) takes one word: kind and a
//   64-bit value. kind 0 prints signed decimal, kind 1 prints "0x" + hex.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one ASCII character
//   per word, leftmost first, with rsp.last set on the final character.
//   One value is worked on at a time; req_stall is high while busy.
//   Decimal: shift-add-3 through a row of 20 digit cells, then up to 19
//   leading zeros dropped, then one character per cycle while rsp_stall
//   allows (sign first if negative).
//   Hex: nibbles load straight into the cells; "0x", up to 15 leading
//   zeros dropped, then one digit per cycle while rsp_stall allows.
//   The output register holds a character while rsp_stall is high; the FSM
//   waits in its character states meanwhile, nothing is lost. The next
//   value can be accepted once the last character sits in the output
//   register, since the FSM returns to idle as it loads that character.
//   rst (synchronous) returns to idle and drops rsp_valid.
`default_nettype none
`include "integer_to_ascii_formatter_unit_defines.svh"
module integer_to_ascii_formatter_unit import itoa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  item_t   req,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output result_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_PRE0,
    S_PREX,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t              state;
  logic [VALUE_W-1:0]  mag;
  logic [STEP_W-1:0]   step;
  logic [REMAIN_W-1:0] remain;
  logic                neg;
  logic                kind;

  logic                accept;
  logic                slot_free;
  logic                char_load;
  logic                top_zero;
  cell_ctl_t           ctl;
  logic [DIGIT_W-1:0]  digits     [NUM_CELLS];
  logic                carries    [NUM_CELLS];
  logic [DIGIT_W-1:0]  load_digits[NUM_CELLS];
  logic [DIGIT_W-1:0]  top_digit;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign char_load = slot_free && (state inside {S_SIGN, S_PRE0, S_PREX, S_EMIT});
  assign top_digit = digits[NUM_CELLS-1];
  assign top_zero  = (top_digit == '0);

  always_comb begin
    ctl.op = CELL_HOLD;
    case (state)
      S_IDLE: if (accept) ctl.op = CELL_LOAD;
      S_CONV: ctl.op = CELL_DABBLE;
      S_SKIP: if (top_zero && remain > REMAIN_W'(1)) ctl.op = CELL_SHIFT;
      S_EMIT: if (slot_free) ctl.op = CELL_SHIFT;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i >= HEX_BASE) begin : g_hex
      assign load_digits[i] = (req.kind == KIND_HEX) ?
                              req.value[(i-HEX_BASE)*DIGIT_W +: DIGIT_W] : '0;
    end else begin : g_pad
      assign load_digits[i] = '0;
    end

    if (i == 0) begin : g_first
      itoa_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .shift_in  (mag[VALUE_W-1]),
        .digit_in  ('0),
        .load_digit(load_digits[i]),
        .digit     (digits[i]),
        .carry     (carries[i])
      );
    end else begin : g_rest
      itoa_digit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .shift_in  (carries[i-1]),
        .digit_in  (digits[i-1]),
        .load_digit(load_digits[i]),
        .digit     (digits[i]),
        .carry     (carries[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      step      <= '0;
      remain    <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !char_load) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind <= req.kind;
            neg  <= req.value[VALUE_W-1];
            mag  <= req.value[VALUE_W-1] ? (~req.value + VALUE_W'(1)) : req.value;
            step <= '0;
            if (req.kind == KIND_HEX) begin
              remain <= REMAIN_W'(HEX_DIGITS);
              state  <= S_PRE0;
            end else begin
              remain <= REMAIN_W'(NUM_CELLS);
              state  <= S_CONV;
            end
          end
        end
        S_CONV: begin
          mag  <= {mag[VALUE_W-2:0], 1'b0};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(VALUE_W - 1)) state <= neg ? S_SIGN : S_SKIP;
        end
        S_SIGN: begin
          if (slot_free) begin
            rsp_valid     <= 1'b1;
            rsp.character <= CHAR_MINUS;
            rsp.last      <= 1'b0;
            state         <= S_SKIP;
          end
        end
        S_PRE0: begin
          if (slot_free) begin
            rsp_valid     <= 1'b1;
            rsp.character <= CHAR_ZERO;
            rsp.last      <= 1'b0;
            state         <= S_PREX;
          end
        end
        S_PREX: begin
          if (slot_free) begin
            rsp_valid     <= 1'b1;
            rsp.character <= CHAR_X;
            rsp.last      <= 1'b0;
            state         <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_zero && remain > REMAIN_W'(1)) begin
            remain <= remain - REMAIN_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp_valid     <= 1'b1;
            rsp.character <= digit_glyph(top_digit);
            rsp.last      <= (remain == REMAIN_W'(1));
            remain        <= remain - REMAIN_W'(1);
            if (remain == REMAIN_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ITOA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE)
  `ITOA_ASSERT_NOW(a_remain_nonzero, clk, rst, state != S_IDLE, remain != '0)
  `ITOA_ASSERT_NEXT(a_conv_runs, clk, rst, state == S_CONV && step != STEP_W'(VALUE_W - 1), state == S_CONV)
  `ITOA_ASSERT_NOW(a_dec_digit_range, clk, rst, state == S_EMIT && kind == KIND_DEC, top_digit <= DEC_MAX)

endmodule
`default_nettype wire

@@ rtl/core/itoa_digit_cell.sv @@
// One digit cell: shift-add-3 step, digit hand-over and load.
`default_nettype none
module itoa_digit_cell import itoa_pkg::*; (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               shift_in,
  input  logic [DIGIT_W-1:0] digit_in,
  input  logic [DIGIT_W-1:0] load_digit,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry
);

  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  end

  assign carry = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:   digit <= load_digit;
      CELL_DABBLE: digit <= {adj[DIGIT_W-2:0], shift_in};
      CELL_SHIFT:  digit <= digit_in;
      default:     digit <= digit;
    endcase
  end

endmodule
`default_nettype wire
